// ===== rtl/core/sbrl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbrl_pkg
// Types and constants shared by the stereo beat-roll loop.
// ----------------------------------------------------------------------------
package sbrl_pkg;

    localparam int CFG_INDEX_BITS = 8;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic [15:0]               cfg_data_t;

    // Register indexes on the configuration channel.
    localparam cfg_index_t REG_LOOP_LENGTH = cfg_index_t'(0);
    localparam cfg_index_t REG_WET_DEPTH   = cfg_index_t'(1);

    localparam cfg_data_t LOOP_LENGTH_RESET = 16'd24000;
    localparam cfg_data_t WET_DEPTH_RESET   = 16'd32768;

    // Unity gain in Q15 and the matching shift.
    localparam cfg_data_t Q15_ONE   = 16'd32768;
    localparam int        Q15_SHIFT = 15;

endpackage

// ===== rtl/core/stereo_beat_roll_loop.sv =====
`timescale 1ns / 1ps
// An accepted word passes through the second-stage register and then the output register.
// One word per cycle while the output is not stalled; the delay stores read and write at most once in a cycle.
// The loop tap comes from the stores' registered read port; a pending write-back to the
// same address is forwarded around it.
// Reset clears control state and returns configuration to its defaults; the stores are not
// swept, since the fill count marks every entry not written since the last clear as zero.
// ----------------------------------------------------------------------------
// stereo_beat_roll_loop
// Stereo beat-roll effect: records audio into circular stores while off and
// replays the last loop length, mixed with the dry input, while engaged.
// ----------------------------------------------------------------------------
module stereo_beat_roll_loop #(
    parameter int DELAY_DEPTH = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    // Configuration write channel.
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  sbrl_pkg::cfg_index_t                      cfg_index,
    input  sbrl_pkg::cfg_data_t                       cfg_data,
    // Input stream.
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // tdata: in_left, in_right, zero padding
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]        s_axis_tdata,
    // tuser: roll_on
    input  logic                                      s_axis_tuser,
    // Output stream.
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // tdata: out_left, out_right, zero padding
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]        m_axis_tdata
);

    import sbrl_pkg::*;

    localparam int TDATA_BITS = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int ADDR_BITS  = $clog2(DELAY_DEPTH);
    localparam int FILL_BITS  = $clog2(DELAY_DEPTH+1);
    localparam int CALC_BITS  = ((ADDR_BITS > 16) ? ADDR_BITS : 16) + 1;
    localparam int MIX_BITS   = SAMPLE_BITS + 18;

    typedef logic        [ADDR_BITS-1:0]   addr_t;
    typedef logic        [FILL_BITS-1:0]   fill_t;
    typedef logic        [CALC_BITS-1:0]   calc_t;
    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [MIX_BITS-1:0]    mix_t;

    // Configuration registers.
    cfg_data_t loop_length_reg;
    cfg_data_t wet_depth_reg;

    // Loop control state.
    addr_t     wr_ptr_reg,   wr_ptr_next;
    fill_t     fill_reg,     fill_next;
    logic      holding_reg,  holding_next;
    cfg_data_t cap_len_reg,  cap_len_next;

    // Delay stores.
    sample_t left_mem  [DELAY_DEPTH];
    sample_t right_mem [DELAY_DEPTH];
    sample_t rd_left_reg;
    sample_t rd_right_reg;

    // Second stage: the accepted word waiting for its tap.
    logic    s2_valid_reg;
    logic    s2_hold_reg;
    logic    s2_tap_ok_reg;
    logic    s2_fwd_reg;
    addr_t   s2_waddr_reg;
    sample_t s2_dry_left_reg;
    sample_t s2_dry_right_reg;
    sample_t s2_fwd_left_reg;
    sample_t s2_fwd_right_reg;

    // Output register.
    logic    out_valid_reg;
    sample_t out_left_reg;
    sample_t out_right_reg;

    logic    in_accept;
    logic    s2_advance;
    sample_t in_left;
    sample_t in_right;
    logic    tap_ok;
    addr_t   rd_addr;
    calc_t   tap_len;
    calc_t   rd_sum;
    logic    fwd_hit;

    sample_t   wet_left;
    sample_t   wet_right;
    sample_t   wr_left;
    sample_t   wr_right;
    cfg_data_t wet_gain;
    sample_t   mix_left;
    sample_t   mix_right;
    logic signed [SAMPLE_BITS:0] diff_left;
    logic signed [SAMPLE_BITS:0] diff_right;
    logic signed [16:0]          gain_s;
    mix_t      acc_left;
    mix_t      acc_right;

    assign cfg_ready     = 1'b1;
    assign s2_advance    = s2_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s2_valid_reg || s2_advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign in_left  = s_axis_tdata[SAMPLE_BITS-1:0];
    assign in_right = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

    // Edge detection on roll_on and the bookkeeping of one push.
    always_comb
    begin
        holding_next = holding_reg;
        cap_len_next = cap_len_reg;
        fill_next    = fill_reg;
        if (s_axis_tuser && !holding_reg)
        begin
            holding_next = 1'b1;
            cap_len_next = loop_length_reg;
        end
        else if (!s_axis_tuser && holding_reg)
        begin
            holding_next = 1'b0;
            fill_next    = '0;
        end

        tap_len = CALC_BITS'(cap_len_next);
        tap_ok  = holding_next && (tap_len != '0) && (tap_len <= CALC_BITS'(fill_next))
                  && (tap_len <= CALC_BITS'(DELAY_DEPTH));
        rd_sum  = CALC_BITS'(wr_ptr_reg) + CALC_BITS'(DELAY_DEPTH) - tap_len;
        if (rd_sum >= CALC_BITS'(DELAY_DEPTH))
        begin
            rd_sum = rd_sum - CALC_BITS'(DELAY_DEPTH);
        end
        rd_addr = rd_sum[ADDR_BITS-1:0];

        if (wr_ptr_reg == addr_t'(DELAY_DEPTH-1))
        begin
            wr_ptr_next = '0;
        end
        else
        begin
            wr_ptr_next = wr_ptr_reg + addr_t'(1);
        end
        if (fill_next != fill_t'(DELAY_DEPTH))
        begin
            fill_next = fill_next + fill_t'(1);
        end
    end

    // The word leaving the second stage writes the same cycle; forward it.
    assign fwd_hit = s2_advance && (s2_waddr_reg == rd_addr);

    // Tap selection, write-back value and the Q15 mix.
    always_comb
    begin
        if (!s2_tap_ok_reg)
        begin
            wet_left  = '0;
            wet_right = '0;
        end
        else if (s2_fwd_reg)
        begin
            wet_left  = s2_fwd_left_reg;
            wet_right = s2_fwd_right_reg;
        end
        else
        begin
            wet_left  = rd_left_reg;
            wet_right = rd_right_reg;
        end
        wr_left  = s2_hold_reg ? wet_left  : s2_dry_left_reg;
        wr_right = s2_hold_reg ? wet_right : s2_dry_right_reg;

        wet_gain = (wet_depth_reg > Q15_ONE) ? Q15_ONE : wet_depth_reg;
        gain_s   = signed'({1'b0, wet_gain});

        // dry*(1-w) + wet*w is rewritten as dry + (wet-dry)*w to use one multiplier.
        diff_left  = (SAMPLE_BITS+1)'(wet_left)  - (SAMPLE_BITS+1)'(s2_dry_left_reg);
        diff_right = (SAMPLE_BITS+1)'(wet_right) - (SAMPLE_BITS+1)'(s2_dry_right_reg);
        acc_left   = (MIX_BITS'(diff_left) * MIX_BITS'(gain_s))
                     + (MIX_BITS'(s2_dry_left_reg) <<< Q15_SHIFT);
        acc_right  = (MIX_BITS'(diff_right) * MIX_BITS'(gain_s))
                     + (MIX_BITS'(s2_dry_right_reg) <<< Q15_SHIFT);
        mix_left   = acc_left[SAMPLE_BITS+Q15_SHIFT-1:Q15_SHIFT];
        mix_right  = acc_right[SAMPLE_BITS+Q15_SHIFT-1:Q15_SHIFT];
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_length_reg <= LOOP_LENGTH_RESET;
            wet_depth_reg   <= WET_DEPTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_LOOP_LENGTH: loop_length_reg <= cfg_data;
                REG_WET_DEPTH:   wet_depth_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Control state and stage valids.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            fill_reg      <= '0;
            holding_reg   <= 1'b0;
            cap_len_reg   <= '0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                wr_ptr_reg  <= wr_ptr_next;
                fill_reg    <= fill_next;
                holding_reg <= holding_next;
                cap_len_reg <= cap_len_next;
            end
            if (in_accept)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_advance)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Second-stage and output payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s2_hold_reg      <= holding_next;
            s2_tap_ok_reg    <= tap_ok;
            s2_fwd_reg       <= fwd_hit;
            s2_waddr_reg     <= wr_ptr_reg;
            s2_dry_left_reg  <= in_left;
            s2_dry_right_reg <= in_right;
            s2_fwd_left_reg  <= wr_left;
            s2_fwd_right_reg <= wr_right;
        end
        if (s2_advance)
        begin
            out_left_reg  <= s2_hold_reg ? mix_left  : s2_dry_left_reg;
            out_right_reg <= s2_hold_reg ? mix_right : s2_dry_right_reg;
        end
    end

    // Delay stores: at most one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (s2_advance)
        begin
            left_mem[s2_waddr_reg]  <= wr_left;
            right_mem[s2_waddr_reg] <= wr_right;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rd_left_reg  <= left_mem[rd_addr];
            rd_right_reg <= right_mem[rd_addr];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_BITS'({out_right_reg, out_left_reg});

endmodule
